@@ sv/ets_pkg.sv @@
// ----------------------------------------------------------------------------
// ets_pkg
// Types and constants shared by the smoothing state update block and its units.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int FRAC_BITS = 16;

  // season ring depth; a power of two so ring indexes wrap by masking
  localparam int SEASON_MAX = 64;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD_LEVEL = 2'd1,
    OP_LOAD_GROWTH = 2'd2,
    OP_LOAD_SEASON = 2'd3
  } op_t;

  localparam logic [2:0] CFG_ERROR_KIND  = 3'd0;
  localparam logic [2:0] CFG_TREND_KIND  = 3'd1;
  localparam logic [2:0] CFG_SEASON_KIND = 3'd2;
  localparam logic [2:0] CFG_LEVEL_GAIN  = 3'd3;
  localparam logic [2:0] CFG_GROWTH_GAIN = 3'd4;
  localparam logic [2:0] CFG_SEASON_GAIN = 3'd5;
  localparam logic [2:0] CFG_DAMPING     = 3'd6;
  localparam logic [2:0] CFG_SEASON_LEN  = 3'd7;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_MUL  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // shared unit operations
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic signed [31:0] value;
    logic [5:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] forecast;
    logic signed [31:0] error_value;
    logic signed [31:0] new_level;
    logic signed [31:0] new_growth;
    logic signed [31:0] new_season;
    logic [1:0]  status;
  } out_item_t;

endpackage

@@ sv/ets_alu.sv @@
// ----------------------------------------------------------------------------
// ets_alu
// Shared saturating add, subtract and Q16.16 multiply, one result per cycle.
// ----------------------------------------------------------------------------
module ets_alu (
  input  ets_pkg::alu_op_t    op,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  output logic signed [31:0]  y,
  output logic                clip
);
  import ets_pkg::*;

  logic signed [32:0] sum;
  logic signed [63:0] prod;
  logic signed [47:0] pq;

  always_comb begin
    sum  = '0;
    prod = a * b;
    pq   = prod[63:16]; // arithmetic shift floors
    y    = '0;
    clip = 1'b0;
    unique case (op)
      ALU_ADD, ALU_SUB: begin
        sum = (op == ALU_ADD) ? (33'(a) + 33'(b)) : (33'(a) - 33'(b));
        if (sum > 33'sh0_7FFF_FFFF) begin
          y = 32'sh7FFF_FFFF; clip = 1'b1;
        end else if (sum < -33'sh0_8000_0000) begin
          y = 32'sh8000_0000; clip = 1'b1;
        end else begin
          y = sum[31:0];
        end
      end
      default: begin
        if (pq > 48'sh7FFF_FFFF) begin
          y = 32'sh7FFF_FFFF; clip = 1'b1;
        end else if (pq < -48'sh8000_0000) begin
          y = 32'sh8000_0000; clip = 1'b1;
        end else begin
          y = pq[31:0];
        end
      end
    endcase
  end

endmodule

@@ sv/ets_div.sv @@
// ----------------------------------------------------------------------------
// ets_div
// Radix-2 signed divider: (a*65536)/b truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module ets_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] q,
  output logic               clip
);
  import ets_pkg::*;

  localparam int NB = 48;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [47:0] num_r, num_nxt;
  logic [31:0] den_r, den_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic signed [31:0] q_r, q_nxt;
  logic        clip_r, clip_nxt;
  logic [48:0] trial;
  logic [47:0] ua;
  logic [48:0] sq;

  always_comb begin
    busy_nxt = busy_r; cnt_nxt = cnt_r; num_nxt = num_r; den_nxt = den_r;
    rem_nxt = rem_r; neg_nxt = neg_r; done_nxt = 1'b0; q_nxt = q_r;
    clip_nxt = clip_r;
    ua = a[31] ? 48'(-{{16{a[31]}}, a}) << 16 : 48'({16'd0, a}) << 16;
    trial = {rem_r[47:0], num_r[47]} - {17'd0, den_r};
    sq = '0;
    if (start) begin
      if (b == 0) begin
        done_nxt = 1'b1; q_nxt = 32'sh7FFF_FFFF; clip_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1; cnt_nxt = 6'(NB); num_nxt = ua;
        den_nxt = b[31] ? 32'(-b) : 32'(b);
        rem_nxt = '0; neg_nxt = a[31] ^ b[31];
      end
    end else if (busy_r) begin
      if (!trial[48]) begin
        rem_nxt = trial; num_nxt = {num_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[47:0], num_r[47]}; num_nxt = {num_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
        sq = neg_r ? -{1'b0, num_nxt} : {1'b0, num_nxt};
        if ($signed(sq) > 49'sh7FFF_FFFF) begin
          q_nxt = 32'sh7FFF_FFFF; clip_nxt = 1'b1;
        end else if ($signed(sq) < -49'sh8000_0000) begin
          q_nxt = 32'sh8000_0000; clip_nxt = 1'b1;
        end else begin
          q_nxt = sq[31:0]; clip_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt; den_r <= den_nxt; rem_r <= rem_nxt; neg_r <= neg_nxt;
    q_r <= q_nxt; clip_r <= clip_nxt;
  end

  assign done = done_r;
  assign q = q_r;
  assign clip = clip_r;

endmodule

@@ sv/ets_smoothing_state_update.sv @@
// ----------------------------------------------------------------------------
// ets_smoothing_state_update
// Error/trend/season exponential smoothing state update in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one item (sample or load). Every item
//   gives exactly one result on out_valid/out_ready/out_data.
//   cfg_we/cfg_index/cfg_data write a register. The user must write only while
//   idle; the block itself does not enforce it. A load passes through S_OUT,
//   which registers the result and raises out_valid. A sample is a sequence
//   of steps on one shared add/multiply unit plus one 48-step radix-2
//   divider. An additive trend needs one division and a multiplicative trend
//   two; the worst case (relative error, multiplicative trend and season)
//   has five divisions.
// Throughput: one item at a time; in_ready is low from accept until the
//   result is transferred.
// Reset: level, growth and the season head clear, registers take their
//   defaults. Season entries are undefined until loaded.
// Stall: a held result stays on out_data; no new item is taken meanwhile.
// ----------------------------------------------------------------------------
module ets_smoothing_state_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ets_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ets_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [16:0]         cfg_data
);
  import ets_pkg::*;

  localparam int AW = (SEASON_MAX > 1) ? $clog2(SEASON_MAX) : 1;
  localparam int LW = $clog2(SEASON_MAX + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_RDW, S_PB, S_Q, S_FC, S_ERR, S_ERRD, S_PM, S_PMD,
    S_PQ, S_LV1, S_LV2, S_R, S_RD2, S_RAT, S_RATD, S_G1, S_G2, S_G3,
    S_T, S_TD, S_N1, S_N2, S_N3, S_OUT
  } st_t;

  st_t st_r;
  logic [1:0]  err_kind_r, trend_kind_r, season_kind_r;
  logic [16:0] alpha_r, beta_r, gamma_r, phi_r;
  logic [6:0]  slen_r;
  logic signed [31:0] level_r, growth_r;
  logic [AW-1:0] head_r;
  logic signed [31:0] mem [SEASON_MAX];
  logic signed [31:0] rd_r;

  in_item_t item_r;
  logic signed [31:0] q_r, pb_r, s_r, fc_r, err_r, p_r, tmp_r, news_r, oldl_r;
  logic undef_r, clip_r;
  out_item_t out_r;
  logic out_valid_r;

  // shared unit
  alu_op_t alu_op;
  logic signed [31:0] alu_a, alu_b, alu_y;
  logic alu_clip;
  ets_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y), .clip(alu_clip));

  logic div_start, div_done, div_clip;
  logic signed [31:0] div_a, div_b, div_q;
  ets_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .a(div_a), .b(div_b),
                 .done(div_done), .q(div_q), .clip(div_clip));

  logic [1:0] tk, sk;
  logic [LW-1:0] m_eff;
  logic [AW-1:0] last_idx, rd_idx, head_dn;
  logic ek_mul;
  assign tk = (trend_kind_r == 2'd3) ? KIND_NONE : trend_kind_r;
  assign sk = (season_kind_r == 2'd3) ? KIND_NONE : season_kind_r;
  assign ek_mul = (err_kind_r == KIND_MUL);
  always_comb begin
    if (slen_r == 7'd0) m_eff = LW'(1);
    else if (32'(slen_r) > SEASON_MAX) m_eff = LW'(SEASON_MAX);
    else m_eff = LW'(slen_r);
  end
  assign last_idx = AW'((32'(head_r) + 32'(m_eff) - 1) % SEASON_MAX);
  assign head_dn = AW'((32'(head_r) + SEASON_MAX - 1) % SEASON_MAX);
  assign rd_idx = last_idx;

  logic signed [31:0] alpha_s, beta_s, gamma_s, phi_s;
  assign alpha_s = 32'(alpha_r);
  assign beta_s = 32'(beta_r);
  assign gamma_s = 32'(gamma_r);
  assign phi_s = 32'(phi_r);

  // set once a division state has started the divider; that state then waits for done
  logic div_wait_r;

  always_comb begin
    alu_op = ALU_ADD; alu_a = '0; alu_b = '0;
    div_start = 1'b0; div_a = '0; div_b = '0;
    unique case (st_r)
      S_PB:  begin alu_op = ALU_MUL; alu_a = phi_s; alu_b = growth_r; end
      S_Q: begin
        if (tk == KIND_MUL) begin alu_op = ALU_MUL; alu_a = level_r; alu_b = growth_r; end
        else begin alu_op = ALU_ADD; alu_a = level_r; alu_b = pb_r; end
      end
      S_FC: begin
        alu_op = (sk == KIND_MUL) ? ALU_MUL : ALU_ADD; alu_a = q_r; alu_b = s_r;
      end
      S_ERR: begin alu_op = ALU_SUB; alu_a = item_r.value; alu_b = fc_r; end
      S_ERRD: begin div_start = !div_wait_r; div_a = err_r; div_b = fc_r; end
      S_PM: begin alu_op = ALU_SUB; alu_a = item_r.value; alu_b = s_r; end
      S_PMD: begin div_start = !div_wait_r; div_a = item_r.value; div_b = s_r; end
      S_PQ: begin alu_op = ALU_SUB; alu_a = p_r; alu_b = q_r; end
      S_LV1: begin alu_op = ALU_MUL; alu_a = alpha_s; alu_b = tmp_r; end
      S_LV2: begin alu_op = ALU_ADD; alu_a = q_r; alu_b = tmp_r; end
      S_R: begin alu_op = ALU_SUB; alu_a = level_r; alu_b = oldl_r; end
      S_RD2: begin div_start = !div_wait_r; div_a = level_r; div_b = oldl_r; end
      S_RATD: begin div_start = !div_wait_r; div_a = beta_s; div_b = alpha_s; end
      S_G1: begin alu_op = ALU_SUB; alu_a = p_r; alu_b = pb_r; end
      S_G2: begin alu_op = ALU_MUL; alu_a = news_r; alu_b = tmp_r; end
      S_G3: begin alu_op = ALU_ADD; alu_a = pb_r; alu_b = tmp_r; end
      S_T: begin alu_op = ALU_SUB; alu_a = item_r.value; alu_b = q_r; end
      S_TD: begin div_start = !div_wait_r; div_a = item_r.value; div_b = q_r; end
      S_N1: begin alu_op = ALU_SUB; alu_a = p_r; alu_b = s_r; end
      S_N2: begin alu_op = ALU_MUL; alu_a = gamma_s; alu_b = tmp_r; end
      S_N3: begin alu_op = ALU_ADD; alu_a = s_r; alu_b = tmp_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_RD) rd_r <= mem[rd_idx];
    if (st_r == S_IDLE && in_valid && !out_valid_r &&
        in_data.operation == OP_LOAD_SEASON)
      mem[AW'((32'(head_r) + 32'(in_data.slot)) % SEASON_MAX)] <= in_data.value;
    if (st_r == S_N3) mem[head_dn] <= alu_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid_r <= 1'b0; div_wait_r <= 1'b0;
      err_kind_r <= 2'd1; trend_kind_r <= 2'd0; season_kind_r <= 2'd0;
      alpha_r <= 17'd32768; beta_r <= '0; gamma_r <= '0; phi_r <= 17'd65536;
      slen_r <= 7'd1; level_r <= '0; growth_r <= '0; head_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ERROR_KIND:  err_kind_r <= cfg_data[1:0];
          CFG_TREND_KIND:  trend_kind_r <= cfg_data[1:0];
          CFG_SEASON_KIND: season_kind_r <= cfg_data[1:0];
          CFG_LEVEL_GAIN:  alpha_r <= cfg_data;
          CFG_GROWTH_GAIN: beta_r <= cfg_data;
          CFG_SEASON_GAIN: gamma_r <= cfg_data;
          CFG_DAMPING:     phi_r <= cfg_data;
          CFG_SEASON_LEN:  slen_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_valid && !out_valid_r) begin
          item_r <= in_data; undef_r <= 1'b0; clip_r <= 1'b0;
          fc_r <= '0; err_r <= '0; news_r <= '0;
          unique case (op_t'(in_data.operation))
            OP_LOAD_LEVEL: begin level_r <= in_data.value; st_r <= S_OUT; end
            OP_LOAD_GROWTH: begin growth_r <= in_data.value; st_r <= S_OUT; end
            OP_LOAD_SEASON: begin news_r <= in_data.value; st_r <= S_OUT; end
            default: begin
              oldl_r <= level_r; pb_r <= '0; q_r <= level_r; s_r <= '0;
              st_r <= S_RD;
            end
          endcase
        end
        S_RD: st_r <= S_RDW;
        S_RDW: begin
          if (sk != KIND_NONE) s_r <= rd_r;
          if (tk == KIND_ADD) st_r <= S_PB;
          else if (tk == KIND_MUL) begin
            pb_r <= growth_r; undef_r <= growth_r[31]; st_r <= S_Q;
          end else st_r <= S_FC;
        end
        S_PB: begin pb_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_Q; end
        S_Q: begin q_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_FC; end
        S_FC: begin
          if (sk != KIND_NONE) begin
            fc_r <= alu_y; clip_r <= clip_r | alu_clip;
          end else fc_r <= q_r;
          st_r <= S_ERR;
        end
        S_ERR: begin
          err_r <= alu_y; clip_r <= clip_r | alu_clip;
          st_r <= ek_mul ? S_ERRD : S_PM;
        end
        S_ERRD: begin
          if (!div_wait_r) div_wait_r <= 1'b1;
          else if (div_done) begin
            div_wait_r <= 1'b0; err_r <= div_q; clip_r <= clip_r | div_clip;
            st_r <= S_PM;
          end
        end
        S_PM: begin
          if (sk == KIND_NONE) begin p_r <= item_r.value; st_r <= S_PQ; end
          else if (sk == KIND_ADD) begin
            p_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_PQ;
          end else st_r <= S_PMD;
        end
        S_PMD: begin
          if (!div_wait_r) div_wait_r <= 1'b1;
          else if (div_done) begin
            div_wait_r <= 1'b0; p_r <= div_q; clip_r <= clip_r | div_clip;
            st_r <= S_PQ;
          end
        end
        S_PQ: begin tmp_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_LV1; end
        S_LV1: begin tmp_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_LV2; end
        S_LV2: begin
          level_r <= alu_y; clip_r <= clip_r | alu_clip;
          if (tk == KIND_ADD) st_r <= S_R;
          else if (tk == KIND_MUL) st_r <= S_RD2;
          else st_r <= (sk != KIND_NONE) ? S_T : S_OUT;
        end
        S_R: begin p_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_RAT; end
        S_RD2: begin
          if (!div_wait_r) div_wait_r <= 1'b1;
          else if (div_done) begin
            div_wait_r <= 1'b0; p_r <= div_q; clip_r <= clip_r | div_clip;
            st_r <= S_RAT;
          end
        end
        S_RAT: st_r <= S_RATD;
        S_RATD: begin
          if (!div_wait_r) div_wait_r <= 1'b1;
          else if (div_done) begin
            div_wait_r <= 1'b0; news_r <= div_q; clip_r <= clip_r | div_clip;
            st_r <= S_G1;
          end
        end
        S_G1: begin tmp_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_G2; end
        S_G2: begin tmp_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_G3; end
        S_G3: begin
          growth_r <= alu_y; clip_r <= clip_r | alu_clip; news_r <= '0;
          st_r <= (sk != KIND_NONE) ? S_T : S_OUT;
        end
        S_T: begin
          if (sk == KIND_ADD) begin
            p_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_N1;
          end else st_r <= S_TD;
        end
        S_TD: begin
          if (!div_wait_r) div_wait_r <= 1'b1;
          else if (div_done) begin
            div_wait_r <= 1'b0; p_r <= div_q; clip_r <= clip_r | div_clip;
            st_r <= S_N1;
          end
        end
        S_N1: begin tmp_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_N2; end
        S_N2: begin tmp_r <= alu_y; clip_r <= clip_r | alu_clip; st_r <= S_N3; end
        S_N3: begin
          news_r <= alu_y; clip_r <= clip_r | alu_clip; head_r <= head_dn;
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_r.forecast <= undef_r ? 32'sd0 : fc_r;
          out_r.error_value <= undef_r ? 32'sd0 : err_r;
          out_r.new_level <= level_r;
          out_r.new_growth <= growth_r;
          out_r.new_season <= news_r;
          out_r.status <= undef_r ? ST_UNDEF : (clip_r ? ST_SAT : ST_OK);
          out_valid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (st_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r) else $error("result dropped");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !div_done) else $error("divider done while idle");
`endif

endmodule

@@ sim/ets_smoothing_state_update_test.sv @@
// ----------------------------------------------------------------------------
// ets_smoothing_state_update_test
// Self-checking bench: predicts every result from a local model of the
// smoothing update and compares it field by field under random flow control.
// ----------------------------------------------------------------------------
module ets_smoothing_state_update_test;
  import ets_pkg::*;

  localparam int SMAX = 64;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint ONE = 65536;
  localparam int LIMIT = 2000000;

  // Holds the predicted state and the queue of predicted results.
  class ets_scoreboard;
    bit [1:0] err_kind, trend_kind, seas_kind;
    longint alpha, beta, gamma, phi;
    int unsigned seas_len;
    longint lvl, grw;
    longint ring [SMAX];
    bit written [SMAX];
    int unsigned head;
    bit clip;
    out_item_t pending [$];
    int errors;

    function new();
      err_kind = 1; trend_kind = KIND_NONE; seas_kind = KIND_NONE;
      alpha = 32768; beta = 0; gamma = 0; phi = 65536; seas_len = 1;
      lvl = 0; grw = 0; head = 0; errors = 0;
      foreach (ring[i]) begin
        ring[i] = 0;
        written[i] = 0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [16:0] d);
      case (idx)
        CFG_ERROR_KIND:  err_kind = d[1:0];
        CFG_TREND_KIND:  trend_kind = d[1:0];
        CFG_SEASON_KIND: seas_kind = d[1:0];
        CFG_LEVEL_GAIN:  alpha = d;
        CFG_GROWTH_GAIN: beta = d;
        CFG_SEASON_GAIN: gamma = d;
        CFG_DAMPING:     phi = d;
        CFG_SEASON_LEN:  seas_len = d[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_len();
      if (seas_len < 1) return 1;
      if (seas_len > SMAX) return SMAX;
      return seas_len;
    endfunction

    // true when a sample would read only season entries already written
    function bit season_ready();
      if (seas_kind != KIND_ADD && seas_kind != KIND_MUL) return 1;
      return written[(head + eff_len() - 1) % SMAX];
    endfunction

    function longint clamp(longint v);
      if (v > VMAX) begin
        clip = 1;
        return VMAX;
      end
      if (v < VMIN) begin
        clip = 1;
        return VMIN;
      end
      return v;
    endfunction

    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp(p >= 0 ? p / ONE : -((-p + ONE - 1) / ONE));
    endfunction

    function longint qdiv(longint a, longint b);
      if (b == 0) begin
        clip = 1;
        return VMAX;
      end
      return clamp((a * ONE) / b);
    endfunction

    function void note_input(in_item_t it);
      longint y, fc, err, news, q, pb, p, old_l, old_b, s_last, r, t;
      bit [1:0] tk, sk;
      bit undef;
      int unsigned m, slot_idx;
      out_item_t o;
      y = longint'(it.value);
      tk = (trend_kind == 2'd3) ? KIND_NONE : trend_kind;
      sk = (seas_kind == 2'd3) ? KIND_NONE : seas_kind;
      m = eff_len();
      fc = 0; err = 0; news = 0; s_last = 0; undef = 0; clip = 0;
      case (op_t'(it.operation))
        OP_LOAD_LEVEL: lvl = y;
        OP_LOAD_GROWTH: grw = y;
        OP_LOAD_SEASON: begin
          slot_idx = (head + it.slot) % SMAX;
          ring[slot_idx] = y;
          written[slot_idx] = 1;
          news = y;
        end
        default: begin
          old_l = lvl;
          old_b = grw;
          if (sk != KIND_NONE) s_last = ring[(head + m - 1) % SMAX];
          if (tk == KIND_NONE) begin
            pb = 0; q = old_l;
          end else if (tk == KIND_ADD) begin
            pb = qmul(phi, old_b); q = clamp(old_l + pb);
          end else begin
            pb = old_b; q = qmul(old_l, old_b);
            undef = old_b < 0;
          end
          fc = q;
          if (sk == KIND_ADD) fc = clamp(q + s_last);
          else if (sk == KIND_MUL) fc = qmul(q, s_last);
          if (err_kind == 2) err = qdiv(clamp(y - fc), fc);
          else err = clamp(y - fc);
          if (undef) begin
            fc = 0; err = 0;
          end
          if (sk == KIND_NONE) p = y;
          else if (sk == KIND_ADD) p = clamp(y - s_last);
          else p = qdiv(y, s_last);
          lvl = clamp(q + qmul(alpha, clamp(p - q)));
          if (tk != KIND_NONE) begin
            r = (tk == KIND_ADD) ? clamp(lvl - old_l) : qdiv(lvl, old_l);
            grw = clamp(pb + qmul(qdiv(beta, alpha), clamp(r - pb)));
          end
          if (sk != KIND_NONE) begin
            t = (sk == KIND_ADD) ? clamp(y - q) : qdiv(y, q);
            news = clamp(s_last + qmul(gamma, clamp(t - s_last)));
            head = (head + SMAX - 1) % SMAX;
            ring[head] = news;
            written[head] = 1;
          end
        end
      endcase
      o.forecast = fc[31:0];
      o.error_value = err[31:0];
      o.new_level = lvl[31:0];
      o.new_growth = grw[31:0];
      o.new_season = news[31:0];
      o.status = undef ? ST_UNDEF : (clip ? ST_SAT : ST_OK);
      pending.push_back(o);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.forecast !== e.forecast) begin
        $error("forecast exp %0d got %0d", e.forecast, got.forecast); errors++;
      end
      if (got.error_value !== e.error_value) begin
        $error("error_value exp %0d got %0d", e.error_value, got.error_value); errors++;
      end
      if (got.new_level !== e.new_level) begin
        $error("new_level exp %0d got %0d", e.new_level, got.new_level); errors++;
      end
      if (got.new_growth !== e.new_growth) begin
        $error("new_growth exp %0d got %0d", e.new_growth, got.new_growth); errors++;
      end
      if (got.new_season !== e.new_season) begin
        $error("new_season exp %0d got %0d", e.new_season, got.new_season); errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [16:0] cfg_data;

  ets_scoreboard smoother = new();
  int cycle_count;
  int hold_cycles;

  ets_smoothing_state_update DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: stall pattern, plus a long hold-off set by the test sequence
  initial begin
    out_ready = 0;
    hold_cycles = 0;
  end
  always @(posedge clk) begin
    if (out_valid && out_ready) smoother.check_result(out_data);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      case (cycle_count[10:9])
        2'd0: out_ready <= 1;
        2'd1: out_ready <= ($urandom_range(3) != 0);
        default: out_ready <= $urandom_range(1);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [16:0] d);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    smoother.set_reg(idx, d);
    cfg_we <= 0;
  endtask

  // valid held until accepted; the caller gives the gap after the item
  task automatic send_item(op_t op, logic [31:0] v, logic [5:0] slot, int gap);
    in_item_t it;
    it.operation = op; it.value = v; it.slot = slot;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    smoother.note_input(it);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (smoother.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic setup(bit [1:0] ek, bit [1:0] tk, bit [1:0] sk, logic [16:0] a,
                       logic [16:0] b, logic [16:0] g, logic [16:0] ph, logic [6:0] m);
    write_reg(CFG_ERROR_KIND, ek);
    write_reg(CFG_TREND_KIND, tk);
    write_reg(CFG_SEASON_KIND, sk);
    write_reg(CFG_LEVEL_GAIN, a);
    write_reg(CFG_GROWTH_GAIN, b);
    write_reg(CFG_SEASON_GAIN, g);
    write_reg(CFG_DAMPING, ph);
    write_reg(CFG_SEASON_LEN, m);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'd0;
      default: return 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
    endcase
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(3) == 0) ? $urandom_range(8) : 0;
  endfunction

  // phase: load the whole ring in use so samples never touch unwritten entries
  task automatic run_phase(int items);
    int unsigned m;
    m = smoother.eff_len();
    for (int k = 0; k < m; k++)
      send_item(OP_LOAD_SEASON, $urandom_range(1) ? 32'h0001_0000 + $urandom_range(65535)
                                                  : rand_value(), 6'(k), rand_gap());
    send_item(OP_LOAD_LEVEL, rand_value(), 6'($urandom), rand_gap());
    send_item(OP_LOAD_GROWTH, $urandom_range(4) == 0 ? rand_value()
                                                     : 32'($urandom_range(70000)), 0, 0);
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(9))
        0: send_item(OP_LOAD_LEVEL, rand_value(), 6'($urandom), rand_gap());
        1: send_item(OP_LOAD_GROWTH, rand_value(), 6'($urandom), rand_gap());
        2: send_item(OP_LOAD_SEASON, rand_value(), 6'($urandom_range(m - 1)), rand_gap());
        default: begin
          if (smoother.season_ready())
            send_item(OP_SAMPLE, rand_value(), 6'($urandom), rand_gap());
        end
      endcase
    end
    drain();
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    cycle_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset defaults, loads at field extremes, undefined growth
    send_item(OP_SAMPLE, 32'h0002_0000, 0, 0);
    send_item(OP_LOAD_LEVEL, 32'h7FFFFFFF, 6'h3F, 0);
    send_item(OP_LOAD_GROWTH, 32'h80000000, 0, 0);
    send_item(OP_SAMPLE, 32'h80000000, 0, 0);
    drain();
    setup(2, KIND_MUL, KIND_MUL, 17'h10000, 17'h10000, 17'h10000, 17'h0, 7'd0);
    send_item(OP_LOAD_SEASON, 32'h0, 0, 0);
    send_item(OP_LOAD_LEVEL, 32'h0, 0, 0);
    send_item(OP_LOAD_GROWTH, 32'hFFFF_0000, 0, 0);
    send_item(OP_SAMPLE, 32'h0001_0000, 0, 0);
    send_item(OP_LOAD_GROWTH, 32'h0, 0, 0);
    send_item(OP_SAMPLE, 32'h7FFFFFFF, 0, 0);
    drain();
    setup(3, 2'd3, 2'd3, 17'd1, 17'h10000, 17'd0, 17'h10000, 7'd127);
    for (int k = 0; k < SMAX; k++) send_item(OP_LOAD_SEASON, 32'(k) << 16, 6'(k), 0);
    send_item(OP_SAMPLE, 32'h0003_0000, 0, 0);
    drain();

    // long receiver hold-off while the sender keeps offering items
    setup(1, KIND_ADD, KIND_ADD, 17'h8000, 17'h4000, 17'h2000, 17'hE000, 7'd4);
    hold_cycles = 400;
    run_phase(20);

    setup(1, KIND_ADD, KIND_ADD, 17'h4000, 17'h1000, 17'h3000, 17'hF000, 7'd12);
    run_phase(60);
    setup(2, KIND_ADD, KIND_MUL, 17'h10000, 17'h8000, 17'h10000, 17'h10000, 7'd1);
    run_phase(50);
    setup(1, KIND_MUL, KIND_ADD, 17'h6000, 17'h2000, 17'h0, 17'h0, 7'd64);
    run_phase(50);
    setup(2, KIND_MUL, KIND_MUL, 17'd1, 17'd0, 17'h8000, 17'h8000, 7'd7);
    run_phase(50);
    setup(1, KIND_NONE, KIND_NONE, 17'h10000, 17'h0, 17'h0, 17'h10000, 7'd3);
    run_phase(30);

    if (smoother.errors == 0 && smoother.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
